>>> hdl/kmp_pkg.sv
package kmp_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SHIFT_W    = 16;
  localparam int unsigned PAT_W      = 2 * CFG_DATA_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_LOW  = 2'd0,
    CFG_CHARS_HIGH = 2'd1,
    CFG_LENGTH     = 2'd2
  } cfg_index_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_INIT,
    ST_BUILD,
    ST_IDLE,
    ST_MATCH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_wr;
    logic init;
    logic build_step;
    logic load;
    logic match_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic build_done;
    logic match_follow;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/kmp_ctrl.sv
module kmp_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  output logic                                cfg_ready_o,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  kmp_pkg::dp_status_t                 status_i,
  output kmp_pkg::dp_cmd_t                    cmd_o
);

  kmp_pkg::state_e state_q, state_d;
  logic            cfg_known;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  assign cfg_known = (cfg_index_i == kmp_pkg::CFG_CHARS_LOW) ||
                     (cfg_index_i == kmp_pkg::CFG_CHARS_HIGH) ||
                     (cfg_index_i == kmp_pkg::CFG_LENGTH);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmp_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      kmp_pkg::ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = kmp_pkg::ST_BUILD;
      end
      kmp_pkg::ST_BUILD: begin
        if (status_i.build_done) begin
          state_d = kmp_pkg::ST_IDLE;
        end else begin
          cmd_o.build_step = 1'b1;
        end
      end
      kmp_pkg::ST_IDLE: begin
        s_ready_o = !cfg_valid_i;
        if (s_valid_i && !cfg_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = kmp_pkg::ST_MATCH;
        end
      end
      kmp_pkg::ST_MATCH: begin
        cmd_o.match_step = 1'b1;
        if (!status_i.match_follow && status_i.out_free) begin
          state_d = kmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kmp_pkg::ST_INIT;
      end
    endcase

    // A known register write restarts the table build.
    if (cfg_valid_i) begin
      cmd_o.cfg_wr = 1'b1;
      if (cfg_known) begin
        cmd_o.init       = 1'b0;
        cmd_o.build_step = 1'b0;
        cmd_o.load       = 1'b0;
        cmd_o.match_step = 1'b0;
        state_d          = kmp_pkg::ST_INIT;
      end
    end
  end

endmodule

>>> hdl/kmp_dp.sv
module kmp_dp #(
  parameter int unsigned MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [kmp_pkg::BYTE_W-1:0]          text_byte_i,
  input  logic                                end_of_text_i,
  input  kmp_pkg::dp_cmd_t                    cmd_i,
  output kmp_pkg::dp_status_t                 status_o,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic                                match_found_o,
  output logic [kmp_pkg::SHIFT_W-1:0]         match_shift_o,
  output logic                                text_done_o
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SW = (POSITION_BITS > kmp_pkg::SHIFT_W) ?
                               POSITION_BITS : kmp_pkg::SHIFT_W;

  // Byte k of the pattern, byte 0 in the lowest bits.
  function automatic logic [kmp_pkg::BYTE_W-1:0] pat_byte(
    input logic [kmp_pkg::PAT_W-1:0] pat,
    input logic [3:0]                k
  );
    return pat[{k, 3'b000} +: kmp_pkg::BYTE_W];
  endfunction

  // Configuration registers.
  logic [kmp_pkg::CFG_DATA_W-1:0] chars_lo_q, chars_hi_q;
  logic [kmp_pkg::LEN_W-1:0]      len_q;
  logic [kmp_pkg::PAT_W-1:0]      pat;
  logic [LW-1:0]                  n_len;

  // Failure table and search state.
  logic [LW-1:0]                  ft_q [MAX_PATTERN+1];
  logic [LW-1:0]                  i_q, i_d, bj_q, bj_d, mc_q, mc_d;
  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic [kmp_pkg::BYTE_W-1:0]     c_q;
  logic                           eot_q;

  // Result register.
  logic                           mvalid_q, mvalid_d;
  logic                           found_q;
  logic [kmp_pkg::SHIFT_W-1:0]    shift_q;
  logic                           done_q;

  logic [kmp_pkg::BYTE_W-1:0]     pj_b, pi_b, pj_m;
  logic                           follow_b, follow_m, hit, found, out_free, resolve;
  logic [LW-1:0]                  v_b, i_next, jn, ft_addr, ft_rd;
  logic [LW:0]                    i_plus;
  logic [SW-1:0]                  shift_sum;

  assign pat = {chars_hi_q, chars_lo_q};

  // Effective length: zero counts as one, large values clamp to the maximum.
  always_comb begin
    if (len_q == '0) begin
      n_len = LW'(1);
    end else if (len_q > kmp_pkg::LEN_W'(MAX_PATTERN)) begin
      n_len = LW'(MAX_PATTERN);
    end else begin
      n_len = LW'(len_q);
    end
  end

  // Table build: compare the candidate prefix byte against byte i.
  assign pj_b     = pat_byte(pat, 4'(bj_q));
  assign pi_b     = pat_byte(pat, 4'(i_q));
  assign follow_b = (bj_q != '0) && (pj_b != pi_b);
  assign v_b      = (pj_b == pi_b) ? bj_q + LW'(1) : '0;
  assign i_next   = i_q + LW'(1);
  assign i_plus   = {1'b0, i_q} + (LW+1)'(1);

  // Text match: compare the next pattern byte against the text byte.
  assign pj_m     = pat_byte(pat, 4'(mc_q));
  assign hit      = (pj_m == c_q);
  assign follow_m = (mc_q != '0) && !hit;
  assign jn       = hit ? mc_q + LW'(1) : mc_q;
  assign found    = (jn == n_len);
  assign out_free = !mvalid_q || m_ready_i;
  assign resolve  = cmd_i.match_step && !follow_m && out_free;

  // Single table read: a failure link, or the link of the full length.
  assign ft_addr = cmd_i.build_step ? bj_q : (follow_m ? mc_q : n_len);
  assign ft_rd   = ft_q[ft_addr];

  // Start offset of a match, low bits kept.
  assign shift_sum = SW'(pos_q) + SW'(1) - SW'(n_len);

  // The build is done once every index below the length has been handled.
  assign status_o.build_done   = (i_plus > {1'b0, n_len});
  assign status_o.match_follow = follow_m;
  assign status_o.out_free     = out_free;

  // Next values of the search state.
  always_comb begin
    i_d      = i_q;
    bj_d     = bj_q;
    mc_d     = mc_q;
    pos_d    = pos_q;
    mvalid_d = mvalid_q;
    if (cmd_i.init) begin
      i_d   = LW'(1);
      bj_d  = '0;
      mc_d  = '0;
      pos_d = '0;
    end
    if (cmd_i.build_step) begin
      if (follow_b) begin
        bj_d = ft_rd;
      end else begin
        i_d  = i_next;
        bj_d = v_b;
      end
    end
    if (cmd_i.load && (mc_q >= n_len)) begin
      mc_d = '0;
    end
    if (cmd_i.match_step && follow_m) begin
      mc_d = ft_rd;
    end
    if (m_ready_i) begin
      mvalid_d = 1'b0;
    end
    if (resolve) begin
      mc_d     = found ? ft_rd : jn;
      mvalid_d = 1'b1;
      if (pos_q != '1) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
      if (eot_q) begin
        mc_d  = '0;
        pos_d = '0;
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_lo_q <= '0;
      chars_hi_q <= '0;
      len_q      <= kmp_pkg::LEN_W'(1);
      i_q        <= LW'(1);
      bj_q       <= '0;
      mc_q       <= '0;
      pos_q      <= '0;
      mvalid_q   <= 1'b0;
    end else begin
      i_q      <= i_d;
      bj_q     <= bj_d;
      mc_q     <= mc_d;
      pos_q    <= pos_d;
      mvalid_q <= mvalid_d;
      if (cmd_i.cfg_wr) begin
        case (cfg_index_i)
          kmp_pkg::CFG_CHARS_LOW:  chars_lo_q <= cfg_data_i;
          kmp_pkg::CFG_CHARS_HIGH: chars_hi_q <= cfg_data_i;
          kmp_pkg::CFG_LENGTH:     len_q      <= cfg_data_i[kmp_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Failure table writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      ft_q[LW'(1)] <= '0;
    end
    if (cmd_i.build_step && !follow_b) begin
      ft_q[i_next] <= v_b;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q   <= text_byte_i;
      eot_q <= end_of_text_i;
    end
    if (resolve) begin
      found_q <= found;
      shift_q <= found ? shift_sum[kmp_pkg::SHIFT_W-1:0] : '0;
      done_q  <= eot_q;
    end
  end

  assign m_valid_o     = mvalid_q;
  assign match_found_o = found_q;
  assign match_shift_o = shift_q;
  assign text_done_o   = done_q;

  // A failure link always points to a shorter prefix.
  a_match_link_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.match_step && follow_m) |-> (ft_rd < mc_q))
    else $error("match failure link does not shrink");

  a_build_link_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.build_step && follow_b) |-> (ft_rd < bj_q))
    else $error("build failure link does not shrink");

  // The matched length stays below the pattern length while matching.
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.match_step |-> (mc_q < n_len))
    else $error("matched count out of range");

  // The last byte of a text leaves the search at its start.
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve && eot_q) |=> ((mc_q == '0) && (pos_q == '0)))
    else $error("end of text did not clear the search");

endmodule

>>> hdl/kmp_pattern_matcher.sv
// Knuth-Morris-Pratt matcher over a byte stream.
// Configuration: write the pattern bytes (index 0 = bytes 0..7, index 1 =
// bytes 8..15) and the pattern length (index 2) on the cfg channel while no
// text is in flight. Each known write rebuilds the failure table and restarts
// the search; writes with any other index are ignored.
// Text enters on the s_axis channel, one byte per transaction, tlast marking
// the last byte of a text. Each byte yields one transaction on m_axis: tuser
// flags a full match ending at this byte, tdata gives its start offset and
// tlast echoes the input tlast. After the last byte the position and matched
// length return to zero.
// Timing: a byte is taken in from the idle state, then the match step follows
// one failure link after another and resolves the byte into the output
// register; a new byte is taken in only once the previous one has resolved.
// The match step has a single table read port. The result is visible the
// cycle after it resolves. The table build after reset or a known write runs
// an init step and then the build steps, during which s_axis_tready is low.
// A stalled m_axis holds its result; the next byte is still taken in and
// waits in the match step until the output register frees up.
module kmp_pattern_matcher #(
  parameter int unsigned MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Text input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [kmp_pkg::BYTE_W-1:0]          s_axis_tdata,   // text_byte
  input  logic                                s_axis_tlast,   // end_of_text
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [kmp_pkg::SHIFT_W-1:0]         m_axis_tdata,   // match_shift
  output logic                                m_axis_tuser,   // match_found
  output logic                                m_axis_tlast    // text_done
);

  kmp_pkg::dp_cmd_t    cmd;
  kmp_pkg::dp_status_t status;

  kmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_ready_o (cfg_ready_o),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kmp_dp #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .text_byte_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_ready_i     (m_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .match_found_o (m_axis_tuser),
    .match_shift_o (m_axis_tdata),
    .text_done_o   (m_axis_tlast)
  );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last result for stray output.
  localparam int unsigned TAIL_CYCLES = 20;
  // Index that no register answers to.
  localparam logic [kmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // Position counter ceiling at the default width.
  localparam logic [kmp_pkg::SHIFT_W-1:0] POS_CEILING = '1;
  localparam int unsigned RANDOM_PHASES = 13;
  localparam int unsigned PHASE_BYTES = 100;

  typedef struct packed {
    logic                        found;
    logic [kmp_pkg::SHIFT_W-1:0] shift;
    logic                        done;
  } match_res_t;

  typedef enum logic {
    ROW_CFG,
    ROW_TEXT
  } row_kind_e;

  // One row of the directed table: a register write or a text byte, with an
  // optional hand-typed result.
  typedef struct packed {
    row_kind_e                      kind;
    logic [kmp_pkg::CFG_IDX_W-1:0]  idx;
    logic [kmp_pkg::CFG_DATA_W-1:0] data;
    logic [kmp_pkg::BYTE_W-1:0]     tbyte;
    logic                           eot;
    logic                           typed;
    logic                           exp_found;
    logic [kmp_pkg::SHIFT_W-1:0]    exp_shift;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 33;
  localparam stim_row_t STIM_TBL [0:NUM_ROWS-1] = '{
    // Pattern after reset is a single zero byte.
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 16'd2},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0},
    // Length zero is taken as one; the write also restarts the position.
    '{ROW_CFG,  kmp_pkg::CFG_LENGTH,    64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  kmp_pkg::CFG_CHARS_LOW, 64'hFFFF_FFFF_FFFF_FFFF,
      8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 16'd0},
    // Overlapping matches, with a write to an unused index that must be ignored.
    '{ROW_CFG,  kmp_pkg::CFG_CHARS_LOW, 64'h0000_0000_0061_6161,
      8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  kmp_pkg::CFG_LENGTH,    64'd3, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  CFG_UNUSED_IDX,         64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 16'd0},
    // Full 16-byte pattern; a length above the maximum is clipped to 16.
    '{ROW_CFG,  kmp_pkg::CFG_CHARS_LOW,  64'h0706_0504_0302_0100,
      8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  kmp_pkg::CFG_CHARS_HIGH, 64'hFF0E_0D0C_0B0A_0908,
      8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  kmp_pkg::CFG_LENGTH,    64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h01, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h02, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h03, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h04, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h05, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h06, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h07, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h08, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h09, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h0A, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h0B, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h0C, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h0D, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'h0E, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_TEXT, kmp_pkg::CFG_CHARS_LOW, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 16'd0}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [kmp_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [kmp_pkg::BYTE_W-1:0]     s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [kmp_pkg::SHIFT_W-1:0]    m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  kmp_pattern_matcher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the matcher: pattern registers, failure links and search state.
  logic [kmp_pkg::CFG_DATA_W-1:0] pat_lo = '0;
  logic [kmp_pkg::CFG_DATA_W-1:0] pat_hi = '0;
  logic [kmp_pkg::LEN_W-1:0]      pat_len = 5'd1;
  logic [kmp_pkg::LEN_W-1:0]      link_tbl [0:kmp_pkg::MAX_PATTERN_DEF];
  logic [kmp_pkg::LEN_W-1:0]      matched_len = '0;
  logic [kmp_pkg::SHIFT_W-1:0]    text_pos = '0;

  match_res_t  match_q [$];
  int unsigned fail_cnt = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_cnt = 0;
  int unsigned idle_cycles = 0;

  function automatic int active_len();
    int n;
    n = int'(pat_len);
    if (n == 0) n = 1;
    if (n > int'(kmp_pkg::MAX_PATTERN_DEF)) n = kmp_pkg::MAX_PATTERN_DEF;
    return n;
  endfunction

  function automatic logic [kmp_pkg::BYTE_W-1:0] pat_at(int k);
    logic [kmp_pkg::PAT_W-1:0] bits;
    bits = {pat_hi, pat_lo};
    return bits[8*(k & 15) +: 8];
  endfunction

  // Rebuild the failure links and restart the search.
  function automatic void rebuild_links();
    int n;
    int j;
    n = active_len();
    for (int i = 0; i <= int'(kmp_pkg::MAX_PATTERN_DEF); i++) link_tbl[i] = '0;
    for (int i = 1; i < n; i++) begin
      j = int'(link_tbl[i]);
      while (j > 0 && pat_at(j) != pat_at(i)) j = int'(link_tbl[j]);
      link_tbl[i+1] = (pat_at(j) == pat_at(i)) ? kmp_pkg::LEN_W'(j + 1) : '0;
    end
    matched_len = '0;
    text_pos = '0;
  endfunction

  function automatic void apply_reg(logic [kmp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [kmp_pkg::CFG_DATA_W-1:0] data);
    case (kmp_pkg::cfg_index_e'(idx))
      kmp_pkg::CFG_CHARS_LOW:  pat_lo = data;
      kmp_pkg::CFG_CHARS_HIGH: pat_hi = data;
      kmp_pkg::CFG_LENGTH:     pat_len = data[kmp_pkg::LEN_W-1:0];
      default:                 return;
    endcase
    rebuild_links();
  endfunction

  // Advance the search by one text byte and return the result it causes.
  function automatic match_res_t scan_byte(logic [kmp_pkg::BYTE_W-1:0] c, logic eot);
    match_res_t  res;
    int          n;
    int          j;
    logic [31:0] start;
    n = active_len();
    j = int'(matched_len);
    res = '0;
    if (j >= n) j = 0;
    while (j > 0 && pat_at(j) != c) j = int'(link_tbl[j]);
    if (pat_at(j) == c) j++;
    if (j == n) begin
      res.found = 1'b1;
      start = 32'(text_pos) + 32'd1 - 32'(n);
      res.shift = start[kmp_pkg::SHIFT_W-1:0];
      j = int'(link_tbl[n]);
    end
    matched_len = kmp_pkg::LEN_W'(j);
    if (text_pos != POS_CEILING) text_pos++;
    if (eot) begin
      matched_len = '0;
      text_pos = '0;
    end
    res.done = eot;
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one text byte and record its expected result once the transaction
  // completes. The valid stays high so a following byte can go back to back.
  task automatic send_byte(input logic [kmp_pkg::BYTE_W-1:0] b, input logic eot,
                           input logic typed, input match_res_t typed_res);
    int unsigned gap;
    match_res_t  res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = eot;
    do @(posedge clk_i); while (!s_axis_tready);
    res = scan_byte(b, eot);
    match_q.push_back(typed ? typed_res : res);
  endtask

  // Stop offering text and wait until every expected result has arrived.
  task automatic wait_drained();
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kmp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i) cfg_valid_i = 1'b0;
  endtask

  // Random text built from pieces of the current pattern, runs of the phase
  // alphabet and the odd arbitrary byte; texts end at random when allowed.
  task automatic play_text(input int unsigned count, input bit allow_eot,
                           input logic [kmp_pkg::BYTE_W-1:0] alpha [4],
                           input int unsigned alpha_n);
    logic [kmp_pkg::BYTE_W-1:0] piece [$];
    int unsigned                sent;
    int unsigned                r;
    int unsigned                plen;
    logic                       eot;
    sent = 0;
    while (sent < count) begin
      piece.delete();
      r = $urandom_range(0, 19);
      if (r < 14) begin
        plen = (r < 9) ? active_len() : $urandom_range(1, active_len());
        for (int k = 0; k < int'(plen); k++) piece.push_back(pat_at(k));
      end else if (r < 19) begin
        repeat ($urandom_range(1, 6)) piece.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
      end else begin
        piece.push_back(kmp_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      foreach (piece[k]) begin
        eot = allow_eot && (k == piece.size() - 1) && ($urandom_range(0, 11) == 0);
        send_byte(piece[k], eot, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    if (stall_cnt > 0) begin
      m_axis_tready = 1'b0;
      stall_cnt--;
    end else begin
      m_axis_tready = 1'b1;
      if ($urandom_range(0, 3) == 0) stall_cnt = pick_gap();
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    match_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (match_q.size() == 0) begin
        $error("result transaction with nothing expected: match_shift=%0d", m_axis_tdata);
        fail_cnt++;
      end else begin
        e = match_q.pop_front();
        if (m_axis_tuser !== e.found) begin
          $error("match_found: expected %0d, actual %0d", e.found, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata !== e.shift) begin
          $error("match_shift: expected %0d, actual %0d", e.shift, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tlast !== e.done) begin
          $error("text_done: expected %0d, actual %0d", e.done, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles that carry no transaction at all.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [kmp_pkg::BYTE_W-1:0]     alpha [4];
    int unsigned                    alpha_n;
    logic [kmp_pkg::CFG_DATA_W-1:0] word;
    logic [kmp_pkg::PAT_W-1:0]      pat_bits;
    logic [kmp_pkg::LEN_W-1:0]      len;
    int unsigned                    r;
    match_res_t                     typed_res;

    rebuild_links();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed table.
    for (int row = 0; row < int'(NUM_ROWS); row++) begin
      if (STIM_TBL[row].kind == ROW_CFG) begin
        wait_drained();
        write_reg(STIM_TBL[row].idx, STIM_TBL[row].data);
      end else begin
        typed_res.found = STIM_TBL[row].exp_found;
        typed_res.shift = STIM_TBL[row].exp_shift;
        typed_res.done = STIM_TBL[row].eot;
        send_byte(STIM_TBL[row].tbyte, STIM_TBL[row].eot, STIM_TBL[row].typed, typed_res);
      end
    end

    // Random phases, each with a fresh alphabet and register setting.
    for (int ph = 0; ph < int'(RANDOM_PHASES); ph++) begin
      wait_drained();
      gaps_on = ($urandom_range(0, 3) != 0);
      alpha_n = $urandom_range(2, 4);
      foreach (alpha[k]) alpha[k] = kmp_pkg::BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) begin
        pat_bits = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        for (int k = 0; k < 16; k++) pat_bits[8*k +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
      end
      r = $urandom_range(0, 9);
      if (r == 0) len = 5'd0;
      else if (r == 1) len = kmp_pkg::LEN_W'($urandom_range(17, 31));
      else if (r == 2) len = 5'd16;
      else len = kmp_pkg::LEN_W'($urandom_range(1, 6));
      word = {59'd0, len};
      if ($urandom_range(0, 3) == 0) word = {$urandom, 27'($urandom), len};
      r = $urandom_range(0, 5);
      if (r >= 2) begin
        write_reg(kmp_pkg::CFG_CHARS_LOW, pat_bits[kmp_pkg::CFG_DATA_W-1:0]);
        write_reg(kmp_pkg::CFG_CHARS_HIGH, pat_bits[kmp_pkg::PAT_W-1:kmp_pkg::CFG_DATA_W]);
      end
      if (r == 1) write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
      write_reg(kmp_pkg::CFG_LENGTH, word);
      play_text(PHASE_BYTES, 1'b1, alpha, alpha_n);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/kmp_pkg.sv
hdl/kmp_ctrl.sv
hdl/kmp_dp.sv
hdl/kmp_pattern_matcher.sv
verif/tb_top.sv
